// ===== rtl/core/e2q_pkg.sv =====
// Shared constants, types and functions for the Euler angle to quaternion converter.
package e2q_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int OUT_FRAC_BITS_DEF   = 14;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int FIELD_W = 16;
	localparam int Q       = 30;
	// Sine and cosine words: Q2.30 plus headroom for CORDIC growth.
	localparam int CW      = 34;
	// Binary angle words (2^32 units per turn), with headroom.
	localparam int TW      = 34;

	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	typedef logic signed [CW-1:0] cs_t;
	typedef logic signed [TW-1:0] ang_t;

	function automatic ang_t atan_turn(input int i);
		case (i)
			0: atan_turn = 34'sh20000000;  1: atan_turn = 34'sh12E4051E;
			2: atan_turn = 34'sh09FB385B;  3: atan_turn = 34'sh051111D4;
			4: atan_turn = 34'sh028B0D43;  5: atan_turn = 34'sh0145D7E1;
			6: atan_turn = 34'sh00A2F61E;  7: atan_turn = 34'sh00517C55;
			8: atan_turn = 34'sh0028BE53;  9: atan_turn = 34'sh00145F2F;
			10: atan_turn = 34'sh000A2F98; 11: atan_turn = 34'sh000517CC;
			12: atan_turn = 34'sh00028BE6; 13: atan_turn = 34'sh000145F3;
			14: atan_turn = 34'sh0000A2FA; 15: atan_turn = 34'sh0000517D;
			16: atan_turn = 34'sh000028BE; 17: atan_turn = 34'sh0000145F;
			18: atan_turn = 34'sh00000A30; 19: atan_turn = 34'sh00000518;
			20: atan_turn = 34'sh0000028C; 21: atan_turn = 34'sh00000146;
			22: atan_turn = 34'sh000000A3; 23: atan_turn = 34'sh00000051;
			24: atan_turn = 34'sh00000029; 25: atan_turn = 34'sh00000014;
			26: atan_turn = 34'sh0000000A; 27: atan_turn = 34'sh00000005;
			28: atan_turn = 34'sh00000003; 29: atan_turn = 34'sh00000001;
			default: atan_turn = '0;
		endcase
	endfunction

	// Sine and cosine of the three half angles travelling together.
	typedef struct packed {
		cs_t cr;
		cs_t sr;
		cs_t cp;
		cs_t sp;
		cs_t cy;
		cs_t sy;
	} trig_t;

endpackage

// ===== rtl/core/e2q_angle.sv =====
// Degree to binary half angle conversion with quadrant fold, two stages.
module e2q_angle #(
	parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [e2q_pkg::FIELD_W-1:0]  ang,
	output e2q_pkg::ang_t                       t_out,
	output logic                                neg_out
);
	// The half angle in turns times 2^32 is (mag * 2^S + 180) / 360 with
	// S = 31 - ANGLE_FRAC_BITS. Dividing top and bottom by 8 leaves
	// floor((mag * K + 22) / 45) with K = 2^(S-3), which splits into
	// mag * (K / 45) plus the quotient of a small remainder term.
	localparam longint      K       = 64'sd1 <<< (28 - ANGLE_FRAC_BITS);
	localparam logic [22:0] KQ      = 23'(K / 45);
	localparam logic [5:0]  KR      = 6'(K % 45);
	// Reciprocal of 45 in Q32, rounded up; exact for dividends below 2^21.
	localparam logic [26:0] RECIP45 = 27'((64'd1 << 32) / 64'd45 + 64'd1);

	logic [16:0] mag;
	logic [31:0] hi_s1;
	logic [20:0] lo_s1;
	logic sgn_s1;
	logic [47:0] lo_prod;
	logic [31:0] quo;
	logic signed [e2q_pkg::TW-1:0] t;

	assign mag = ang[15] ? 17'(-$signed({ang[15], ang})) : 17'({1'b0, ang});

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1  <= 32'(48'(mag) * 48'(KQ));
			lo_s1  <= 21'(27'(mag) * 27'(KR) + 27'd22);
			sgn_s1 <= ang[15];
		end
	end

	// The remainder term is divided by 45 with a reciprocal multiplication.
	always_comb begin
		lo_prod = 48'(lo_s1) * 48'(RECIP45);
		quo     = hi_s1 + 32'(lo_prod >> 32);
		t       = sgn_s1 ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (t > e2q_pkg::ang_t'(34'sd1 <<< 30)) begin
				t_out   <= t - (34'sd1 <<< 31);
				neg_out <= 1'b1;
			end else if (t < -(34'sd1 <<< 30)) begin
				t_out   <= t + (34'sd1 <<< 31);
				neg_out <= 1'b1;
			end else begin
				t_out   <= t;
				neg_out <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/core/e2q_cordic.sv =====
// Pipelined rotation-mode CORDIC for the sine and cosine of one angle.
module e2q_cordic #(
	parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  e2q_pkg::ang_t t_in,
	input  logic          neg_in,
	output e2q_pkg::cs_t  c_out,
	output e2q_pkg::cs_t  s_out
);
	e2q_pkg::cs_t  x_s [CORDIC_STAGES+1];
	e2q_pkg::cs_t  y_s [CORDIC_STAGES+1];
	e2q_pkg::ang_t t_s [CORDIC_STAGES+1];
	logic          n_s [CORDIC_STAGES+1];

	assign x_s[0] = e2q_pkg::GAIN_Q30;
	assign y_s[0] = '0;
	assign t_s[0] = t_in;
	assign n_s[0] = neg_in;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= n_s[i];
				if (t_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					t_s[i+1] <= t_s[i] - e2q_pkg::atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					t_s[i+1] <= t_s[i] + e2q_pkg::atan_turn(i);
				end
			end
		end
	end

	assign c_out = n_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];
	assign s_out = n_s[CORDIC_STAGES] ? -y_s[CORDIC_STAGES] : y_s[CORDIC_STAGES];
endmodule

// ===== rtl/core/e2q_combine.sv =====
// Triple products, sums, rounding and saturation, in registered stages.
module e2q_combine #(
	parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  e2q_pkg::trig_t                      trig,
	output logic signed [e2q_pkg::FIELD_W-1:0]  qx,
	output logic signed [e2q_pkg::FIELD_W-1:0]  qy,
	output logic signed [e2q_pkg::FIELD_W-1:0]  qz,
	output logic signed [e2q_pkg::FIELD_W-1:0]  qw
);
	localparam int CW = e2q_pkg::CW;
	localparam int Q  = e2q_pkg::Q;
	localparam int SH = Q - OUT_FRAC_BITS;

	e2q_pkg::trig_t t_s1;
	e2q_pkg::cs_t cycp_s1, sysp_s1, cysp_s1, sycp_s1;
	e2q_pkg::cs_t p_s2 [8];
	logic signed [CW+1:0] sum_s3 [4];
	logic signed [CW+1:0] v [4];
	logic signed [e2q_pkg::FIELD_W-1:0] o [4];

	function automatic e2q_pkg::cs_t mq(input e2q_pkg::cs_t a, input e2q_pkg::cs_t b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		mq = CW'(p >>> Q);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= trig;
			cycp_s1 <= mq(trig.cy, trig.cp);
			sysp_s1 <= mq(trig.sy, trig.sp);
			cysp_s1 <= mq(trig.cy, trig.sp);
			sycp_s1 <= mq(trig.sy, trig.cp);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= mq(cycp_s1, t_s1.sr);
			p_s2[1] <= mq(sysp_s1, t_s1.cr);
			p_s2[2] <= mq(cysp_s1, t_s1.cr);
			p_s2[3] <= mq(sycp_s1, t_s1.sr);
			p_s2[4] <= mq(sycp_s1, t_s1.cr);
			p_s2[5] <= mq(cysp_s1, t_s1.sr);
			p_s2[6] <= mq(cycp_s1, t_s1.cr);
			p_s2[7] <= mq(sysp_s1, t_s1.sr);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3[0] <= (CW+2)'(p_s2[0]) - (CW+2)'(p_s2[1]);
			sum_s3[1] <= (CW+2)'(p_s2[2]) + (CW+2)'(p_s2[3]);
			sum_s3[2] <= (CW+2)'(p_s2[4]) - (CW+2)'(p_s2[5]);
			sum_s3[3] <= (CW+2)'(p_s2[6]) + (CW+2)'(p_s2[7]);
		end
	end

	localparam logic signed [CW+1:0] LIM = (CW+2)'(1) <<< OUT_FRAC_BITS;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (SH > 0)
				v[k] = (sum_s3[k] + ((CW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
			else
				v[k] = sum_s3[k];
			if (v[k] > LIM)
				v[k] = LIM;
			if (v[k] < -LIM)
				v[k] = -LIM;
			o[k] = v[k][e2q_pkg::FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx <= o[0];
			qy <= o[1];
			qz <= o[2];
			qw <= o[3];
		end
	end
endmodule

// ===== rtl/core/euler_to_quaternion.sv =====
// Top level of the Euler angle (Z-Y-X) to unit quaternion converter.
//
// An input word carries roll, pitch and yaw in signed 1/128 degree steps and
// is taken when in_valid and in_ready are both high. Each output word carries
// the quaternion x, y, z and w in signed Q1.14, clamped to plus or minus one,
// and is handed over when out_valid and out_ready are both high.
//
// Two stages turn each angle into a folded binary half angle, one CORDIC
// stage per iteration follows, and four stages form the triple products,
// the sums and the rounded result. Throughput is one word per clock while
// the receiver does not stall; the three angles run in parallel CORDIC
// pipelines, and the pipeline depth sets the latency.
//
// The pipeline advances as a whole whenever its last stage is empty or being
// drained, so a stalled receiver holds every stage in place and nothing is
// lost or repeated; in_ready falls only while the output word waits.
// Reset clears all valid bits; data registers carry no reset.
module euler_to_quaternion #(
	parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS   = e2q_pkg::OUT_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = e2q_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [e2q_pkg::FIELD_W-1:0]  roll_deg,
	input  logic signed [e2q_pkg::FIELD_W-1:0]  pitch_deg,
	input  logic signed [e2q_pkg::FIELD_W-1:0]  yaw_deg,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [e2q_pkg::FIELD_W-1:0]  quat_x,
	output logic signed [e2q_pkg::FIELD_W-1:0]  quat_y,
	output logic signed [e2q_pkg::FIELD_W-1:0]  quat_z,
	output logic signed [e2q_pkg::FIELD_W-1:0]  quat_w
);
	localparam int DEPTH = CORDIC_STAGES + 6;

	logic [DEPTH-1:0] valid_q;
	logic en;
	e2q_pkg::ang_t tr, tp, ty;
	logic nr, np, ny;
	e2q_pkg::trig_t trig;

	// The whole pipeline moves when the output slot is free or being taken.
	assign en        = !valid_q[DEPTH-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = valid_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[DEPTH-2:0], in_valid};
		end
	end

	e2q_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_r (
		.clk(clk), .en(en), .ang(roll_deg), .t_out(tr), .neg_out(nr));
	e2q_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_p (
		.clk(clk), .en(en), .ang(pitch_deg), .t_out(tp), .neg_out(np));
	e2q_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_y (
		.clk(clk), .en(en), .ang(yaw_deg), .t_out(ty), .neg_out(ny));

	e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_r (
		.clk(clk), .en(en), .t_in(tr), .neg_in(nr), .c_out(trig.cr), .s_out(trig.sr));
	e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_p (
		.clk(clk), .en(en), .t_in(tp), .neg_in(np), .c_out(trig.cp), .s_out(trig.sp));
	e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_y (
		.clk(clk), .en(en), .t_in(ty), .neg_in(ny), .c_out(trig.cy), .s_out(trig.sy));

	e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
		.clk(clk), .en(en), .trig(trig),
		.qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w));
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the Euler angle to quaternion converter.
module tb;

	localparam int ANG_FRAC = e2q_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int OUT_FRAC = e2q_pkg::OUT_FRAC_BITS_DEF;
	localparam int STAGES   = e2q_pkg::CORDIC_STAGES_DEF;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [15:0] w;
	} quat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] roll_deg, pitch_deg, yaw_deg;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;

	angles_t angle_words[$];
	quat_t   expected_quats[$];
	int      mismatches;
	int      idle_free;
	bit      in_taken;

	euler_to_quaternion i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
	);

	// Arctangent of 2^-i in binary angle units, indexed by CORDIC stage.
	localparam longint ATAN_LUT[30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	// Arithmetic right shift on a signed 64-bit value rounds toward minus infinity.
	function automatic longint floor_sh(longint v, int n);
		return v >>> n;
	endfunction

	// Cosine and sine (Q30) of half of an angle given in fixed point degrees.
	function automatic void half_angle_trig(input logic signed [15:0] a, output longint c,
			output longint s);
		longint mag, t, xv, yv, nx;
		bit flip;
		mag = (a < 0) ? -longint'(a) : longint'(a);
		t = ((mag << (31 - ANG_FRAC)) + 180) / 360;
		if (a < 0)
			t = -t;
		flip = 0;
		if (t > (64'sd1 <<< 30)) begin
			t -= (64'sd1 <<< 31);
			flip = 1;
		end else if (t < -(64'sd1 <<< 30)) begin
			t += (64'sd1 <<< 31);
			flip = 1;
		end
		xv = 652032874;
		yv = 0;
		for (int i = 0; i < STAGES && i < 30; i++) begin
			if (t >= 0) begin
				nx = xv - floor_sh(yv, i);
				yv = yv + floor_sh(xv, i);
				t -= ATAN_LUT[i];
			end else begin
				nx = xv + floor_sh(yv, i);
				yv = yv - floor_sh(xv, i);
				t += ATAN_LUT[i];
			end
			xv = nx;
		end
		c = flip ? -xv : xv;
		s = flip ? -yv : yv;
	endfunction

	function automatic longint triple(longint a, longint b, longint c);
		return floor_sh(floor_sh(a * b, 30) * c, 30);
	endfunction

	// Rounds a Q30 sum to the output format and clamps it to plus or minus one.
	function automatic logic signed [15:0] round_clamp(longint v);
		longint lim;
		lim = 64'sd1 <<< OUT_FRAC;
		if (30 - OUT_FRAC > 0)
			v = floor_sh(v + (64'sd1 <<< (30 - OUT_FRAC - 1)), 30 - OUT_FRAC);
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v[15:0];
	endfunction

	function automatic quat_t rotation_quat(angles_t a);
		longint cr, sr, cp, sp, cy, sy;
		quat_t q;
		half_angle_trig(a.roll, cr, sr);
		half_angle_trig(a.pitch, cp, sp);
		half_angle_trig(a.yaw, cy, sy);
		q.x = round_clamp(triple(cy, cp, sr) - triple(sy, sp, cr));
		q.y = round_clamp(triple(cy, sp, cr) + triple(sy, cp, sr));
		q.z = round_clamp(triple(sy, cp, cr) - triple(cy, sp, sr));
		q.w = round_clamp(triple(cy, cp, cr) + triple(sy, sp, sr));
		return q;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// Angles near the fold points, 90 degrees, zero and the ends of the 16-bit range, or any 16-bit value.
	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(23040 + $urandom_range(0, 4) - 2);    // near 180 degrees
			3: return 16'(-23040 + $urandom_range(0, 4) - 2);
			4: return 16'(11520 + $urandom_range(0, 4) - 2);    // near 90 degrees
			5: return 16'($urandom_range(0, 8) - 4);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic signed [15:0] corner[8];
		angles_t a;
		corner = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd23040, -16'sd23040,
			16'sd23041, -16'sd23041, 16'sd11520};
		mismatches = 0;
		for (int i = 0; i < 8; i++) begin
			angle_words.push_back(angles_t'{corner[i], corner[(i + 3) % 8],
				corner[(i + 5) % 8]});
		end
		for (int i = 0; i < 8; i++) begin
			angle_words.push_back(angles_t'{corner[i], corner[i], corner[i]});
		end
		angle_words.push_back(angles_t'{16'sh0001, 16'shFFFF, 16'sh5555});
		angle_words.push_back(angles_t'{16'shAAAA, 16'sh5555, 16'shAAAA});
		for (int i = 0; i < 2000; i++) begin
			a.roll = pick_angle();
			a.pitch = pick_angle();
			a.yaw = pick_angle();
			angle_words.push_back(a);
		end
		wait (angle_words.size() == 0 && !in_valid);
		wait (expected_quats.size() == 0);
		repeat (STAGES + 20) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Idling is turned off for a long stretch in the middle of the run.
	function automatic bit take_break();
		if (idle_free > 600 && idle_free < 1400)
			return 0;
		return $urandom_range(0, 99) < 22;
	endfunction

	// Driver: a word is held unchanged until the converter takes it.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			roll_deg <= '0;
			pitch_deg <= '0;
			yaw_deg <= '0;
			out_ready <= 0;
			idle_free <= 0;
		end else begin
			idle_free <= idle_free + 1;
			out_ready <= !take_break();
			if (!in_valid || in_taken) begin
				if (angle_words.size() != 0 && !take_break()) begin
					{roll_deg, pitch_deg, yaw_deg} <= angle_words.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: predict on every accepted input word, check every output word.
	always @(posedge clk) begin
		quat_t got, want;
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_quats.push_back(rotation_quat(angles_t'{roll_deg, pitch_deg,
					yaw_deg}));
			if (out_valid && out_ready) begin
				got = '{quat_x, quat_y, quat_z, quat_w};
				if (expected_quats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output word %h", got);
				end else begin
					want = expected_quats.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: x %0d/%0d y %0d/%0d z %0d/%0d w %0d/%0d (exp/got)",
								want.x, got.x, want.y, got.y, want.z, got.z, want.w, got.w);
					end
				end
			end
		end
	end

endmodule
